// ----- sv/drdu_pkg.sv -----
`default_nettype none

package drdu_pkg;

   localparam int GAME_WIDTH   = 128;
   localparam int GAME_HEIGHT  = 128;
   localparam int PANEL_WIDTH  = 240;
   localparam int PANEL_HEIGHT = 240;
   localparam int FRAME_CELLS  = GAME_WIDTH * GAME_HEIGHT;

   localparam int ADDR_W  = $clog2(FRAME_CELLS);
   localparam int COL_W   = $clog2(GAME_WIDTH);
   localparam int ROW_W   = $clog2(GAME_HEIGHT + 1);
   localparam int XPOS_W  = $clog2(GAME_WIDTH + 1);
   localparam int COORD_W = 18;
   localparam int REP_W   = 8;
   localparam int PH_W    = 4;

   localparam int COL_OFS = (PANEL_WIDTH - GAME_WIDTH) / 2;
   localparam int ROW_OFS = (PANEL_HEIGHT - GAME_HEIGHT) / 2;

   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_FETCH = 1'b1;

   localparam logic [7:0] CMD_CASET = 8'h2A;
   localparam logic [7:0] CMD_RASET = 8'h2B;
   localparam logic [7:0] CMD_RAMWR = 8'h2C;
   localparam logic [7:0] BLUE_MUL  = 8'h55;

   localparam logic [PH_W-1:0] PH_CASET = 4'd0;
   localparam logic [PH_W-1:0] PH_X0_HI = 4'd1;
   localparam logic [PH_W-1:0] PH_X0_LO = 4'd2;
   localparam logic [PH_W-1:0] PH_X1_HI = 4'd3;
   localparam logic [PH_W-1:0] PH_X1_LO = 4'd4;
   localparam logic [PH_W-1:0] PH_RASET = 4'd5;
   localparam logic [PH_W-1:0] PH_Y0_HI = 4'd6;
   localparam logic [PH_W-1:0] PH_Y0_LO = 4'd7;
   localparam logic [PH_W-1:0] PH_Y1_HI = 4'd8;
   localparam logic [PH_W-1:0] PH_Y1_LO = 4'd9;
   localparam logic [PH_W-1:0] PH_RAMWR = 4'd10;
   localparam logic [PH_W-1:0] HDR_LEN  = 4'd11;

   function automatic logic [ADDR_W-1:0] frame_addr(logic [ROW_W-1:0] row,
                                                    logic [XPOS_W-1:0] col);
      int t;
      t = int'(row) * GAME_WIDTH + int'(col);
      return ADDR_W'(t % FRAME_CELLS);
   endfunction

   function automatic logic signed [COORD_W-1:0] map_coord(logic scale, logic is_row,
                                                           logic [8:0] g);
      int unsigned t;
      int s;
      t = 0;
      s = 0;
      if (scale) begin
         if (is_row)
            t = (int'(g) * PANEL_HEIGHT + GAME_HEIGHT - 1) / GAME_HEIGHT;
         else
            t = (int'(g) * PANEL_WIDTH + GAME_WIDTH - 1) / GAME_WIDTH;
         return COORD_W'(t);
      end
      s = (is_row ? ROW_OFS : COL_OFS) + int'(g);
      return COORD_W'(s);
   endfunction

   function automatic logic [REP_W-1:0] map_reps(logic scale, logic is_row, logic [8:0] g);
      logic signed [COORD_W-1:0] d;
      d = map_coord(scale, is_row, g + 9'd1) - map_coord(scale, is_row, g);
      return (d > 0) ? REP_W'(d) : '0;
   endfunction

   function automatic logic [15:0] rgb565(logic [7:0] p);
      logic [15:0] r;
      logic [15:0] g;
      logic [15:0] b;
      r = ((16'(p[7:5]) * 16'd9) >> 1) << 11;
      g = (16'(p[4:2]) * 16'd9) << 5;
      b = (16'(p[1:0]) * 16'(BLUE_MUL)) >> 3;
      return r | g | b;
   endfunction

endpackage

`default_nettype wire

// ----- sv/drdu_ram.sv -----
`default_nettype none

module drdu_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16384
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en)
         mem[wr_addr] <= wr_data;
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire

// ----- sv/dirty_region_display_updater.sv -----
// channel   direction  words
// req_      in         opcode, pixel_index, pixel_value
// rsp_      out        spi_byte, is_command, end_of_frame, empty_res
// csr_      in         scale_mode
//
// Rows are compared against the sent copy and copied into it column by column, paced by
// the single read port of the frame stores.
// Reset is synchronous; the frame stores are not cleared. A stalled result holds the
// sequencer until it is taken; configuration words are taken in every cycle.
`default_nettype none

module dirty_region_display_updater (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic       req_opcode,
   input  wire logic [13:0] req_pixel_index,
   input  wire logic [7:0] req_pixel_value,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output logic [7:0]      rsp_spi_byte,
   output logic            rsp_is_command,
   output logic            rsp_end_of_frame,
   output logic            rsp_empty_res,
   input  wire logic       csr_valid,
   output logic            csr_ready,
   input  wire logic       csr_scale_mode
);

   localparam int AW = drdu_pkg::ADDR_W;
   localparam int CW = drdu_pkg::COL_W;
   localparam int RW = drdu_pkg::ROW_W;
   localparam int XW = drdu_pkg::XPOS_W;
   localparam int QW = drdu_pkg::REP_W;
   localparam int PW = drdu_pkg::PH_W;

   typedef enum logic [3:0] {
      ST_IDLE, ST_SETTLE, ST_FIND, ST_SCAN, ST_SCAN_LAST, ST_ROW_EVAL,
      ST_COPY, ST_COPY_LAST, ST_FETCH, ST_PIXEL, ST_EMIT
   } state_type;

   state_type state_ff, state_in;
   logic sent_valid_ff, sent_valid_in, sending_ff, sending_in, in_run_ff, in_run_in;
   logic scale_mode_ff, scale_mode_in, frame_scale_ff, frame_scale_in, first_ff, first_in;
   logic [RW-1:0] row_cursor_ff, row_cursor_in, run_first_row_ff, run_first_row_in;
   logic [CW-1:0] span_first_col_ff, span_first_col_in, span_last_col_ff, span_last_col_in;
   logic [PW-1:0] emit_phase_ff, emit_phase_in;
   logic [RW-1:0] cur_gy_ff, cur_gy_in;
   logic [XW-1:0] cur_gx_ff, cur_gx_in;
   logic [QW-1:0] cur_gy_rep_ff, cur_gy_rep_in, cur_gx_rep_ff, cur_gx_rep_in;
   logic cur_half_ff, cur_half_in;
   logic [CW-1:0] scan_col_ff, scan_col_in, pipe_col_ff, pipe_col_in;
   logic pipe_valid_ff, pipe_valid_in, pipe_copy_ff, pipe_copy_in;
   logic [AW-1:0] pipe_addr_ff, pipe_addr_in;
   logic found_ff, found_in;
   logic [CW-1:0] scan_lo_ff, scan_lo_in, scan_hi_ff, scan_hi_in;
   logic [7:0] byte_ff, byte_in;
   logic cmd_ff, cmd_in, eof_ff, eof_in, empty_ff, empty_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [7:0] rsp_byte_ff, rsp_byte_in;
   logic rsp_cmd_ff, rsp_cmd_in, rsp_eof_ff, rsp_eof_in, rsp_empty_ff, rsp_empty_in;

   logic settle_hit, settle_miss;
   logic [AW-1:0] rd_addr;
   logic [7:0] new_rd, sent_rd;
   logic new_wr_en;
   logic [QW-1:0] gy_reps, gx_reps;
   logic [8:0] hdr_g;
   logic hdr_row, hdr_sub;
   logic [15:0] hdr_u16, pix_rgb;
   logic [7:0] hdr_byte;
   logic hdr_cmd;

   assign req_ready = (state_ff == ST_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_spi_byte = rsp_byte_ff;
   assign rsp_is_command = rsp_cmd_ff;
   assign rsp_end_of_frame = rsp_eof_ff;
   assign rsp_empty_res = rsp_empty_ff;

   assign new_wr_en = req_valid && req_ready && (req_opcode == drdu_pkg::OP_WRITE)
                      && !sending_ff && ({1'b0, req_pixel_index} < 15'(drdu_pkg::FRAME_CELLS));

   always_comb begin
      case (state_ff)
         ST_SCAN: rd_addr = drdu_pkg::frame_addr(row_cursor_ff, XW'(scan_col_ff));
         ST_COPY: rd_addr = drdu_pkg::frame_addr(cur_gy_ff, XW'(scan_col_ff));
         default: rd_addr = drdu_pkg::frame_addr(cur_gy_ff, cur_gx_ff);
      endcase
   end

   drdu_ram #(.WIDTH(8), .DEPTH(drdu_pkg::FRAME_CELLS)) u_new_frame (
      .clock(clock),
      .wr_en(new_wr_en),
      .wr_addr(AW'(req_pixel_index)),
      .wr_data(req_pixel_value),
      .rd_addr(rd_addr),
      .rd_data(new_rd)
   );

   drdu_ram #(.WIDTH(8), .DEPTH(drdu_pkg::FRAME_CELLS)) u_sent_frame (
      .clock(clock),
      .wr_en(pipe_valid_ff && pipe_copy_ff),
      .wr_addr(pipe_addr_ff),
      .wr_data(new_rd),
      .rd_addr(rd_addr),
      .rd_data(sent_rd)
   );

   assign gy_reps = drdu_pkg::map_reps(frame_scale_ff, 1'b1, 9'(cur_gy_ff));
   assign gx_reps = drdu_pkg::map_reps(frame_scale_ff, 1'b0, 9'(cur_gx_ff));
   assign pix_rgb = drdu_pkg::rgb565(new_rd);

   always_comb begin
      hdr_g = '0;
      hdr_row = 1'b0;
      hdr_sub = 1'b0;
      case (emit_phase_ff)
         drdu_pkg::PH_X0_HI, drdu_pkg::PH_X0_LO: hdr_g = 9'(span_first_col_ff);
         drdu_pkg::PH_X1_HI, drdu_pkg::PH_X1_LO: begin
            hdr_g = 9'(span_last_col_ff) + 9'd1;
            hdr_sub = 1'b1;
         end
         drdu_pkg::PH_Y0_HI, drdu_pkg::PH_Y0_LO: begin
            hdr_g = 9'(run_first_row_ff);
            hdr_row = 1'b1;
         end
         drdu_pkg::PH_Y1_HI, drdu_pkg::PH_Y1_LO: begin
            hdr_g = 9'(row_cursor_ff);
            hdr_row = 1'b1;
            hdr_sub = 1'b1;
         end
         default: hdr_g = '0;
      endcase
      hdr_u16 = 16'(drdu_pkg::map_coord(frame_scale_ff, hdr_row, hdr_g)) - 16'(hdr_sub);
      hdr_cmd = 1'b0;
      case (emit_phase_ff)
         drdu_pkg::PH_CASET: begin
            hdr_byte = drdu_pkg::CMD_CASET;
            hdr_cmd = 1'b1;
         end
         drdu_pkg::PH_RASET: begin
            hdr_byte = drdu_pkg::CMD_RASET;
            hdr_cmd = 1'b1;
         end
         drdu_pkg::PH_RAMWR: begin
            hdr_byte = drdu_pkg::CMD_RAMWR;
            hdr_cmd = 1'b1;
         end
         drdu_pkg::PH_X0_HI, drdu_pkg::PH_X1_HI, drdu_pkg::PH_Y0_HI, drdu_pkg::PH_Y1_HI:
            hdr_byte = hdr_u16[15:8];
         default: hdr_byte = hdr_u16[7:0];
      endcase
   end

   always_comb begin
      state_in = state_ff;
      sent_valid_in = sent_valid_ff;
      sending_in = sending_ff;
      in_run_in = in_run_ff;
      scale_mode_in = scale_mode_ff;
      frame_scale_in = frame_scale_ff;
      first_in = first_ff;
      row_cursor_in = row_cursor_ff;
      run_first_row_in = run_first_row_ff;
      span_first_col_in = span_first_col_ff;
      span_last_col_in = span_last_col_ff;
      emit_phase_in = emit_phase_ff;
      cur_gy_in = cur_gy_ff;
      cur_gx_in = cur_gx_ff;
      cur_gy_rep_in = cur_gy_rep_ff;
      cur_gx_rep_in = cur_gx_rep_ff;
      cur_half_in = cur_half_ff;
      scan_col_in = scan_col_ff;
      pipe_valid_in = 1'b0;
      pipe_copy_in = pipe_copy_ff;
      pipe_col_in = pipe_col_ff;
      pipe_addr_in = pipe_addr_ff;
      found_in = found_ff;
      scan_lo_in = scan_lo_ff;
      scan_hi_in = scan_hi_ff;
      byte_in = byte_ff;
      cmd_in = cmd_ff;
      eof_in = eof_ff;
      empty_in = empty_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_byte_in = rsp_byte_ff;
      rsp_cmd_in = rsp_cmd_ff;
      rsp_eof_in = rsp_eof_ff;
      rsp_empty_in = rsp_empty_ff;
      settle_hit = 1'b0;
      settle_miss = 1'b0;

      if (csr_valid)
         scale_mode_in = csr_scale_mode;

      if (pipe_valid_ff && !pipe_copy_ff && (new_rd != sent_rd)) begin
         if (!found_ff)
            scan_lo_in = pipe_col_ff;
         scan_hi_in = pipe_col_ff;
         found_in = 1'b1;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid && req_opcode == drdu_pkg::OP_FETCH) begin
               if (sending_ff) begin
                  state_in = ST_FETCH;
               end else begin
                  frame_scale_in = scale_mode_ff;
                  row_cursor_in = '0;
                  emit_phase_in = drdu_pkg::HDR_LEN;
                  cur_gy_in = '0;
                  first_in = 1'b1;
                  state_in = ST_SETTLE;
               end
            end
         end
         ST_SETTLE: begin
            if (emit_phase_ff < drdu_pkg::HDR_LEN) begin
               settle_hit = 1'b1;
            end else if (cur_gy_ff >= row_cursor_ff) begin
               state_in = ST_FIND;
            end else if (cur_gy_rep_ff >= gy_reps) begin
               scan_col_in = '0;
               state_in = ST_COPY;
            end else if (cur_gx_ff > XW'(span_last_col_ff)) begin
               cur_gy_rep_in = cur_gy_rep_ff + QW'(1);
               cur_gx_in = XW'(span_first_col_ff);
               cur_gx_rep_in = '0;
               cur_half_in = 1'b0;
            end else if (cur_gx_rep_ff >= gx_reps) begin
               cur_gx_in = cur_gx_ff + XW'(1);
               cur_gx_rep_in = '0;
               cur_half_in = 1'b0;
            end else begin
               settle_hit = 1'b1;
            end
         end
         ST_FIND: begin
            if (row_cursor_ff >= RW'(drdu_pkg::GAME_HEIGHT)) begin
               if (in_run_ff) begin
                  in_run_in = 1'b0;
                  emit_phase_in = drdu_pkg::PH_CASET;
                  state_in = ST_SETTLE;
               end else begin
                  settle_miss = 1'b1;
               end
            end else if (!sent_valid_ff) begin
               found_in = 1'b1;
               scan_lo_in = '0;
               scan_hi_in = CW'(drdu_pkg::GAME_WIDTH - 1);
               state_in = ST_ROW_EVAL;
            end else begin
               found_in = 1'b0;
               scan_col_in = '0;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            pipe_valid_in = 1'b1;
            pipe_copy_in = 1'b0;
            pipe_col_in = scan_col_ff;
            pipe_addr_in = rd_addr;
            scan_col_in = scan_col_ff + CW'(1);
            if (scan_col_ff == CW'(drdu_pkg::GAME_WIDTH - 1))
               state_in = ST_SCAN_LAST;
         end
         ST_SCAN_LAST: state_in = ST_ROW_EVAL;
         ST_ROW_EVAL: begin
            if (!in_run_ff) begin
               if (found_ff) begin
                  run_first_row_in = row_cursor_ff;
                  span_first_col_in = scan_lo_ff;
                  span_last_col_in = scan_hi_ff;
                  in_run_in = 1'b1;
               end
               row_cursor_in = row_cursor_ff + RW'(1);
               state_in = ST_FIND;
            end else if (found_ff) begin
               if (scan_lo_ff < span_first_col_ff)
                  span_first_col_in = scan_lo_ff;
               if (scan_hi_ff > span_last_col_ff)
                  span_last_col_in = scan_hi_ff;
               row_cursor_in = row_cursor_ff + RW'(1);
               state_in = ST_FIND;
            end else begin
               in_run_in = 1'b0;
               emit_phase_in = drdu_pkg::PH_CASET;
               state_in = ST_SETTLE;
            end
         end
         ST_COPY: begin
            pipe_valid_in = 1'b1;
            pipe_copy_in = 1'b1;
            pipe_col_in = scan_col_ff;
            pipe_addr_in = rd_addr;
            scan_col_in = scan_col_ff + CW'(1);
            if (scan_col_ff == CW'(drdu_pkg::GAME_WIDTH - 1))
               state_in = ST_COPY_LAST;
         end
         ST_COPY_LAST: begin
            cur_gy_in = cur_gy_ff + RW'(1);
            cur_gy_rep_in = '0;
            cur_gx_in = XW'(span_first_col_ff);
            cur_gx_rep_in = '0;
            cur_half_in = 1'b0;
            state_in = ST_SETTLE;
         end
         ST_FETCH: state_in = ST_PIXEL;
         ST_PIXEL: begin
            if (emit_phase_ff < drdu_pkg::HDR_LEN) begin
               byte_in = hdr_byte;
               cmd_in = hdr_cmd;
               emit_phase_in = emit_phase_ff + PW'(1);
               if (emit_phase_ff == drdu_pkg::PH_RAMWR) begin
                  cur_gy_in = run_first_row_ff;
                  cur_gy_rep_in = '0;
                  cur_gx_in = XW'(span_first_col_ff);
                  cur_gx_rep_in = '0;
                  cur_half_in = 1'b0;
               end
            end else begin
               byte_in = cur_half_ff ? pix_rgb[7:0] : pix_rgb[15:8];
               cmd_in = 1'b0;
               if (!cur_half_ff) begin
                  cur_half_in = 1'b1;
               end else begin
                  cur_half_in = 1'b0;
                  cur_gx_rep_in = cur_gx_rep_ff + QW'(1);
               end
            end
            first_in = 1'b0;
            state_in = ST_SETTLE;
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_byte_in = byte_ff;
               rsp_cmd_in = cmd_ff;
               rsp_eof_in = eof_ff;
               rsp_empty_in = empty_ff;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      if (settle_hit) begin
         if (first_ff) begin
            sending_in = 1'b1;
            state_in = ST_FETCH;
         end else begin
            eof_in = 1'b0;
            empty_in = 1'b0;
            state_in = ST_EMIT;
         end
      end

      if (settle_miss) begin
         sent_valid_in = 1'b1;
         if (first_ff) begin
            byte_in = '0;
            cmd_in = 1'b0;
            eof_in = 1'b0;
            empty_in = 1'b1;
         end else begin
            sending_in = 1'b0;
            eof_in = 1'b1;
            empty_in = 1'b0;
         end
         state_in = ST_EMIT;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         sent_valid_ff <= 1'b0;
         sending_ff <= 1'b0;
         in_run_ff <= 1'b0;
         scale_mode_ff <= 1'b0;
         frame_scale_ff <= 1'b0;
         first_ff <= 1'b0;
         row_cursor_ff <= '0;
         run_first_row_ff <= '0;
         span_first_col_ff <= '0;
         span_last_col_ff <= '0;
         emit_phase_ff <= '0;
         cur_gy_ff <= '0;
         cur_gx_ff <= '0;
         cur_gy_rep_ff <= '0;
         cur_gx_rep_ff <= '0;
         cur_half_ff <= 1'b0;
         scan_col_ff <= '0;
         pipe_valid_ff <= 1'b0;
         pipe_copy_ff <= 1'b0;
         found_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         sent_valid_ff <= sent_valid_in;
         sending_ff <= sending_in;
         in_run_ff <= in_run_in;
         scale_mode_ff <= scale_mode_in;
         frame_scale_ff <= frame_scale_in;
         first_ff <= first_in;
         row_cursor_ff <= row_cursor_in;
         run_first_row_ff <= run_first_row_in;
         span_first_col_ff <= span_first_col_in;
         span_last_col_ff <= span_last_col_in;
         emit_phase_ff <= emit_phase_in;
         cur_gy_ff <= cur_gy_in;
         cur_gx_ff <= cur_gx_in;
         cur_gy_rep_ff <= cur_gy_rep_in;
         cur_gx_rep_ff <= cur_gx_rep_in;
         cur_half_ff <= cur_half_in;
         scan_col_ff <= scan_col_in;
         pipe_valid_ff <= pipe_valid_in;
         pipe_copy_ff <= pipe_copy_in;
         found_ff <= found_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pipe_col_ff <= pipe_col_in;
      pipe_addr_ff <= pipe_addr_in;
      scan_lo_ff <= scan_lo_in;
      scan_hi_ff <= scan_hi_in;
      byte_ff <= byte_in;
      cmd_ff <= cmd_in;
      eof_ff <= eof_in;
      empty_ff <= empty_in;
      rsp_byte_ff <= rsp_byte_in;
      rsp_cmd_ff <= rsp_cmd_in;
      rsp_eof_ff <= rsp_eof_in;
      rsp_empty_ff <= rsp_empty_in;
   end

`ifndef SYNTHESIS
   a_no_write_while_sending: assert property (@(posedge clock) disable iff (reset)
      new_wr_en |-> !sending_ff)
      else $error("frame write taken during a send");

   a_empty_word_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_empty_ff) |-> (rsp_byte_ff == 8'd0 && !rsp_cmd_ff && !rsp_eof_ff))
      else $error("empty word carries data");

   a_phase_bound: assert property (@(posedge clock) disable iff (reset)
      emit_phase_ff <= drdu_pkg::HDR_LEN)
      else $error("emit phase out of range");

   a_pipe_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !pipe_valid_ff)
      else $error("memory walk still active in idle");
`endif

endmodule

`default_nettype wire
